### hw/rtl/dsq_pkg.sv
`timescale 1ns / 1ps
package dsq_pkg;

    localparam int MODE_W  = 2;
    localparam int SPIKE_W = 16;
    localparam int DELAY_W = 4;
    localparam int SIZE_W  = 17;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_PUSH  = 2'd0;
    localparam t_mode MODE_END   = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;
    localparam t_mode MODE_CLEAR = 2'd3;

endpackage

### hw/rtl/dsq_vram.sv
`timescale 1ns / 1ps
module dsq_vram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // an entry never written since reset or clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

### hw/rtl/dsq_range_filter.sv
`timescale 1ns / 1ps
module dsq_range_filter
    import dsq_pkg::*;
(
    input  logic [SPIKE_W-1:0] i_index,
    input  logic [SPIKE_W-1:0] i_origin,
    input  logic [SIZE_W-1:0]  i_size,
    output logic               o_hit,
    output logic [SPIKE_W-1:0] o_offset
);

    assign o_offset = i_index - i_origin;
    // upper bound checked as offset < size, so origin + size never wraps
    assign o_hit = (i_index >= i_origin) && ({1'b0, o_offset} < i_size);

endmodule

### hw/rtl/delayed_spike_queue_unit.sv
`timescale 1ns / 1ps
// Spike delay queue. Push, end-of-step and clear requests are accepted when
// the result register is free. A query with a delay below STEP_HISTORY reads
// the two step marks from the mark memory, then does one store read and one
// range check for every store entry of the requested step, then delivers the
// final result; the walk is bounded by SPIKE_CAPACITY entries and stalls while
// the result register is held by the consumer. A larger delay gets an empty
// result. Stored data lives in two synchronous memories with separate read and
// write ports whose entries read as zero until written after reset or clear.
module delayed_spike_queue_unit
    import dsq_pkg::*;
#(
    parameter int SPIKE_CAPACITY = 63,
    parameter int STEP_HISTORY   = 15,
    parameter int NEURON_ID_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [SPIKE_W-1:0] i_neuron_index,
    input  logic [DELAY_W-1:0] i_delay,
    input  logic [SPIKE_W-1:0] i_range_origin,
    input  logic [SIZE_W-1:0]  i_range_size,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SPIKE_W-1:0] o_spike_value,
    output logic               o_valid_res,
    output logic               o_last,
    output logic               o_overflow
);

    localparam int STORE_LEN = SPIKE_CAPACITY + 1;
    localparam int MARK_LEN  = STEP_HISTORY + 1;
    localparam int SAW       = $clog2(STORE_LEN);
    localparam int MAW       = $clog2(MARK_LEN);
    localparam int STORE_W   = (NEURON_ID_BITS < SPIKE_W) ? NEURON_ID_BITS : SPIKE_W;
    localparam int CW        = ((MAW > DELAY_W) ? MAW : DELAY_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MEND  = 3'd1;
    localparam logic [2:0] S_MSTOP = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_SCHK  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [SAW-1:0]     r_wc, n_wc;
    logic [SAW-1:0]     r_fill, n_fill;
    logic [MAW-1:0]     r_mc, n_mc;
    logic [MAW-1:0]     r_end_i, n_end_i;
    logic [SAW-1:0]     r_pos, n_pos;
    logic [SAW-1:0]     r_stop, n_stop;
    logic [SAW-1:0]     r_guard, n_guard;
    logic               r_have, n_have;
    logic [SPIKE_W-1:0] r_pend, n_pend;
    logic [SPIKE_W-1:0] r_origin, n_origin;
    logic [SIZE_W-1:0]  r_size, n_size;

    logic               r_out_valid;
    logic [SPIKE_W-1:0] r_out_value;
    logic               r_out_vres;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               ld;
    logic [SPIKE_W-1:0] ld_value;
    logic               ld_vres;
    logic               ld_last;
    logic               ld_ovf;

    logic               can_load;
    logic               in_acc;
    logic               clear;

    logic               s_we, s_re;
    logic [STORE_W-1:0] s_rdata;
    logic               m_we, m_re;
    logic [MAW-1:0]     m_waddr, m_raddr;
    logic [SAW-1:0]     m_rdata;

    logic [CW-1:0]      mc_ext, d_ext, end_calc;
    logic [MAW-1:0]     end_i, beg_i, mc_next;
    logic               more;
    logic               hit;
    logic [SPIKE_W-1:0] hit_off;

    assign can_load = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && can_load;
    assign in_acc   = i_valid && o_ready;

    // mark slot of the requested step, and of the boundary before it
    assign mc_ext   = CW'(r_mc);
    assign d_ext    = CW'(i_delay);
    assign end_calc = (mc_ext >= d_ext) ? (mc_ext - d_ext)
                                        : (mc_ext + CW'(MARK_LEN) - d_ext);
    assign end_i    = MAW'(end_calc);
    assign beg_i    = (end_i == '0) ? MAW'(MARK_LEN - 1) : end_i - 1'b1;
    assign mc_next  = (r_mc == MAW'(MARK_LEN - 1)) ? '0 : r_mc + 1'b1;

    assign more = (r_pos != r_stop) && (r_guard < SAW'(SPIKE_CAPACITY));

    dsq_range_filter u_filter (
        .i_index  (SPIKE_W'(s_rdata)),
        .i_origin (r_origin),
        .i_size   (r_size),
        .o_hit    (hit),
        .o_offset (hit_off)
    );

    always_comb begin
        n_state  = r_state;
        n_wc     = r_wc;
        n_fill   = r_fill;
        n_mc     = r_mc;
        n_end_i  = r_end_i;
        n_pos    = r_pos;
        n_stop   = r_stop;
        n_guard  = r_guard;
        n_have   = r_have;
        n_pend   = r_pend;
        n_origin = r_origin;
        n_size   = r_size;
        ld       = 1'b0;
        ld_value = '0;
        ld_vres  = 1'b0;
        ld_last  = 1'b1;
        ld_ovf   = 1'b0;
        clear    = 1'b0;
        s_we     = 1'b0;
        s_re     = 1'b0;
        m_we     = 1'b0;
        m_re     = 1'b0;
        m_waddr  = mc_next;
        m_raddr  = beg_i;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_PUSH: begin
                            ld = 1'b1;
                            if (r_fill == SAW'(SPIKE_CAPACITY)) begin
                                ld_ovf = 1'b1;
                            end else begin
                                s_we   = 1'b1;
                                n_wc   = (r_wc == SAW'(STORE_LEN - 1)) ? '0 : r_wc + 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        MODE_END: begin
                            m_we   = 1'b1;
                            n_mc   = mc_next;
                            n_fill = '0;
                        end
                        MODE_QUERY: begin
                            n_origin = i_range_origin;
                            n_size   = i_range_size;
                            if (32'(i_delay) >= STEP_HISTORY) begin
                                ld = 1'b1;
                            end else begin
                                m_re    = 1'b1;
                                n_end_i = end_i;
                                n_state = S_MEND;
                            end
                        end
                        MODE_CLEAR: begin
                            clear  = 1'b1;
                            n_wc   = '0;
                            n_fill = '0;
                            n_mc   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_MEND: begin
                m_re    = 1'b1;
                m_raddr = r_end_i;
                n_pos   = m_rdata;
                n_state = S_MSTOP;
            end
            S_MSTOP: begin
                n_stop  = m_rdata;
                n_guard = '0;
                n_have  = 1'b0;
                n_state = S_SREAD;
            end
            S_SREAD: begin
                if (more) begin
                    s_re    = 1'b1;
                    n_pos   = (r_pos == SAW'(STORE_LEN - 1)) ? '0 : r_pos + 1'b1;
                    n_guard = r_guard + 1'b1;
                    n_state = S_SCHK;
                end else if (can_load) begin
                    // flush the held match as the final result, or report none
                    ld       = 1'b1;
                    ld_value = r_have ? r_pend : '0;
                    ld_vres  = r_have;
                    n_state  = S_IDLE;
                end
            end
            S_SCHK: begin
                if (!hit) begin
                    n_state = S_SREAD;
                end else if (!r_have) begin
                    n_pend  = hit_off;
                    n_have  = 1'b1;
                    n_state = S_SREAD;
                end else if (can_load) begin
                    // a newer match proves the held one is not last
                    ld       = 1'b1;
                    ld_value = r_pend;
                    ld_vres  = 1'b1;
                    ld_last  = 1'b0;
                    n_pend   = hit_off;
                    n_state  = S_SREAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories are written only from idle, so a walk never overlaps a write
    dsq_vram #(
        .DEPTH (STORE_LEN),
        .WIDTH (STORE_W)
    ) u_spike_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear),
        .i_we    (s_we),
        .i_waddr (r_wc),
        .i_wdata (i_neuron_index[STORE_W-1:0]),
        .i_re    (s_re),
        .i_raddr (r_pos),
        .o_rdata (s_rdata)
    );

    dsq_vram #(
        .DEPTH (MARK_LEN),
        .WIDTH (SAW)
    ) u_mark_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (r_wc),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wc        <= '0;
            r_fill      <= '0;
            r_mc        <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wc    <= n_wc;
            r_fill  <= n_fill;
            r_mc    <= n_mc;
            r_have  <= n_have;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_i  <= n_end_i;
        r_pos    <= n_pos;
        r_stop   <= n_stop;
        r_guard  <= n_guard;
        r_pend   <= n_pend;
        r_origin <= n_origin;
        r_size   <= n_size;
        if (ld) begin
            r_out_value <= ld_value;
            r_out_vres  <= ld_vres;
            r_out_last  <= ld_last;
            r_out_ovf   <= ld_ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_spike_value = r_out_value;
    assign o_valid_res   = r_out_vres;
    assign o_last        = r_out_last;
    assign o_overflow    = r_out_ovf;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SAW'(SPIKE_CAPACITY))
        else $error("step fill exceeds capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_PUSH && r_fill != SAW'(SPIKE_CAPACITY))
        |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("stored push did not advance fill");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_CLEAR)
        |=> (r_wc == '0 && r_fill == '0 && r_mc == '0))
        else $error("clear left cursors set");

    a_ovf_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_last && !o_valid_res))
        else $error("overflow flag on a query result");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHK) |-> (r_guard != '0 && r_guard <= SAW'(SPIKE_CAPACITY)))
        else $error("walk step count out of bounds");

endmodule

### tb/delayed_spike_queue_unit_tb.sv
`timescale 1ns / 1ps
import dsq_pkg::*;

typedef struct packed {
    logic [SPIKE_W-1:0] spike_value;
    logic               valid_res;
    logic               last;
    logic               overflow;
} t_spike_result;

class spike_queue_scoreboard;
    localparam int CAPACITY  = 63;
    localparam int STORE_LEN = CAPACITY + 1;
    localparam int HISTORY   = 15;
    localparam int MARK_LEN  = HISTORY + 1;

    logic [SPIKE_W-1:0] spike_mem [STORE_LEN];
    int                 step_mark [MARK_LEN];
    int                 wr_ptr;
    int                 fill_count;
    int                 mark_ptr;

    t_spike_result      expected_spikes [$];
    int                 errors;
    int                 checked;
    int                 dropped;
    int                 hit_total;
    int                 mode_count [4];

    function new();
        errors    = 0;
        checked   = 0;
        dropped   = 0;
        hit_total = 0;
        foreach (mode_count[i]) mode_count[i] = 0;
        clear_state();
    endfunction

    function void clear_state();
        foreach (spike_mem[i]) spike_mem[i] = '0;
        foreach (step_mark[i]) step_mark[i] = 0;
        wr_ptr     = 0;
        fill_count = 0;
        mark_ptr   = 0;
    endfunction

    function int pending();
        return expected_spikes.size();
    endfunction

    // Predict the results of one accepted request.
    function void note_request(t_mode mode, logic [SPIKE_W-1:0] index,
                               logic [DELAY_W-1:0] dly, logic [SPIKE_W-1:0] origin,
                               logic [SIZE_W-1:0] size);
        t_spike_result res;
        int            hits;
        int            pos;
        int            stop;
        int            guard;
        int            x;
        int            lo;
        int            span;
        int            back;
        mode_count[mode]++;
        res = '0;
        case (mode)
            MODE_PUSH: begin
                res.last = 1'b1;
                if (fill_count >= CAPACITY) begin
                    res.overflow = 1'b1;
                    dropped++;
                end else begin
                    spike_mem[wr_ptr] = index;
                    wr_ptr = (wr_ptr + 1) % STORE_LEN;
                    fill_count++;
                end
                expected_spikes.push_back(res);
            end
            MODE_END: begin
                mark_ptr = (mark_ptr + 1) % MARK_LEN;
                step_mark[mark_ptr] = wr_ptr;
                fill_count = 0;
            end
            MODE_CLEAR: begin
                clear_state();
            end
            default: begin
                hits = 0;
                back = int'(dly);
                lo   = int'(origin);
                span = int'(size);
                // a delay past the history answers like an empty step
                if (back < HISTORY) begin
                    pos   = step_mark[(mark_ptr + MARK_LEN - back - 1) % MARK_LEN];
                    stop  = step_mark[(mark_ptr + MARK_LEN - back) % MARK_LEN];
                    guard = 0;
                    while (pos != stop && guard < CAPACITY) begin
                        x = int'(spike_mem[pos]);
                        if (x >= lo && (x - lo) < span) begin
                            res.spike_value = SPIKE_W'(x - lo);
                            res.valid_res   = 1'b1;
                            expected_spikes.push_back(res);
                            hits++;
                        end
                        pos = (pos + 1) % STORE_LEN;
                        guard++;
                    end
                end
                hit_total += hits;
                if (hits == 0) begin
                    res = '0;
                    res.last = 1'b1;
                    expected_spikes.push_back(res);
                end else begin
                    expected_spikes[expected_spikes.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    function void check_result(t_spike_result got);
        t_spike_result want;
        if (expected_spikes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value %0h valid %0b last %0b overflow %0b",
                     $time, got.spike_value, got.valid_res, got.last, got.overflow);
            return;
        end
        want = expected_spikes.pop_front();
        checked++;
        if (want !== got) begin
            errors++;
            if (errors <= 40) begin
                if (want.spike_value !== got.spike_value)
                    $display("%0t: spike_value expected %0h actual %0h",
                             $time, want.spike_value, got.spike_value);
                if (want.valid_res !== got.valid_res)
                    $display("%0t: valid_res expected %0b actual %0b",
                             $time, want.valid_res, got.valid_res);
                if (want.last !== got.last)
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, got.last);
                if (want.overflow !== got.overflow)
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, got.overflow);
            end
        end
    endfunction
endclass

module delayed_spike_queue_unit_tb;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [MODE_W-1:0]  i_mode         = '0;
    logic [SPIKE_W-1:0] i_neuron_index = '0;
    logic [DELAY_W-1:0] i_delay        = '0;
    logic [SPIKE_W-1:0] i_range_origin = '0;
    logic [SIZE_W-1:0]  i_range_size   = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [SPIKE_W-1:0] o_spike_value;
    logic               o_valid_res;
    logic               o_last;
    logic               o_overflow;

    spike_queue_scoreboard sb;
    bit                    idle_on = 1'b1;
    int                    requests_sent = 0;
    int                    ready_hold = 0;
    bit                    burst_done = 1'b0;
    bit                    drained = 1'b0;

    delayed_spike_queue_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_neuron_index (i_neuron_index),
        .i_delay        (i_delay),
        .i_range_origin (i_range_origin),
        .i_range_size   (i_range_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_spike_value  (o_spike_value),
        .o_valid_res    (o_valid_res),
        .o_last         (o_last),
        .o_overflow     (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check accepted results, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result('{o_spike_value, o_valid_res, o_last, o_overflow});
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(1, 5) - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_request(input t_mode mode, input logic [SPIKE_W-1:0] index,
                                input logic [DELAY_W-1:0] dly,
                                input logic [SPIKE_W-1:0] origin,
                                input logic [SIZE_W-1:0] size);
        i_mode         <= mode;
        i_neuron_index <= index;
        i_delay        <= dly;
        i_range_origin <= origin;
        i_range_size   <= size;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(mode, index, dly, origin, size);
        requests_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Unused fields carry random bits.
    task automatic push_spike(input logic [SPIKE_W-1:0] index);
        send_request(MODE_PUSH, index, DELAY_W'($urandom), SPIKE_W'($urandom),
                     SIZE_W'($urandom));
    endtask

    task automatic end_step();
        send_request(MODE_END, SPIKE_W'($urandom), DELAY_W'($urandom),
                     SPIKE_W'($urandom), SIZE_W'($urandom));
    endtask

    task automatic clear_all();
        send_request(MODE_CLEAR, SPIKE_W'($urandom), DELAY_W'($urandom),
                     SPIKE_W'($urandom), SIZE_W'($urandom));
    endtask

    task automatic query_step(input logic [DELAY_W-1:0] dly,
                              input logic [SPIKE_W-1:0] origin,
                              input logic [SIZE_W-1:0] size);
        send_request(MODE_QUERY, SPIKE_W'($urandom), dly, origin, size);
    endtask

    // Hold off new requests until all results are in.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_query();
        logic [DELAY_W-1:0] dly;
        logic [SPIKE_W-1:0] origin;
        logic [SIZE_W-1:0]  size;
        dly = ($urandom_range(0, 9) == 0) ? DELAY_W'(15) : DELAY_W'($urandom_range(0, 14));
        case ($urandom_range(0, 3))
            0: begin
                origin = '0;
                size   = SIZE_W'(17'h10000);
            end
            1: begin
                origin = SPIKE_W'($urandom);
                size   = SIZE_W'($urandom);
            end
            2: begin
                origin = SPIKE_W'($urandom_range(0, 32));
                size   = SIZE_W'($urandom_range(0, 48));
            end
            default: begin
                origin = SPIKE_W'($urandom_range(0, 16'h7FFF));
                size   = SIZE_W'($urandom_range(16'h4000, 17'h1FFFF));
            end
        endcase
        query_step(dly, origin, size);
    endtask

    task automatic random_step();
        int n;
        if (!burst_done && requests_sent > 150 || $urandom_range(0, 39) == 0) begin
            n = $urandom_range(62, 68);
            burst_done = 1'b1;
        end else begin
            n = $urandom_range(0, 6);
        end
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                push_spike(SPIKE_W'($urandom_range(0, 40)));
            else
                push_spike(SPIKE_W'($urandom));
        end
        end_step();
        repeat ($urandom_range(0, 2)) random_query();
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        query_step(4'd0, 16'h0000, 17'h10000);
        push_spike(16'h0000);
        push_spike(16'hFFFF);
        push_spike(16'h1234);
        push_spike(16'h8000);
        end_step();
        query_step(4'd0, 16'h0000, 17'h10000);
        query_step(4'd0, 16'hFFFF, 17'h00001);
        query_step(4'd0, 16'hFFFF, 17'h1FFFF);
        query_step(4'd0, 16'h1234, 17'h00000);
        query_step(4'd0, 16'h1235, 17'h06DCB);
        end_step();
        query_step(4'd0, 16'h0000, 17'h1FFFF);
        query_step(4'd1, 16'h0000, 17'h1FFFF);
        query_step(4'd14, 16'h0000, 17'h1FFFF);
        query_step(4'd15, 16'h0000, 17'h1FFFF);
        push_spike(16'hAAAA);
        push_spike(16'h5555);
        end_step();
        clear_all();
        query_step(4'd1, 16'h0000, 17'h1FFFF);
        push_spike(16'h0007);
        end_step();
        query_step(4'd0, 16'h0000, 17'h1FFFF);
        drain_results();

        // random part
        while (requests_sent < 330) begin
            idle_on = (requests_sent < 120) || (requests_sent >= 160 && requests_sent < 260);
            if (!drained && requests_sent >= 200) begin
                drain_results();
                drained = 1'b1;
            end
            case ($urandom_range(0, 19))
                0: clear_all();
                1: send_request(t_mode'($urandom_range(0, 3)), SPIKE_W'($urandom),
                                DELAY_W'($urandom), SPIKE_W'($urandom), SIZE_W'($urandom));
                default: random_step();
            endcase
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d requests: %0d push, %0d end step, %0d query, %0d clear",
                 requests_sent, sb.mode_count[MODE_PUSH], sb.mode_count[MODE_END],
                 sb.mode_count[MODE_QUERY], sb.mode_count[MODE_CLEAR]);
        $display("checked %0d results, %0d query hits, %0d spikes dropped at capacity",
                 sb.checked, sb.hit_total, sb.dropped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

### delayed_spike_queue_unit.f
hw/rtl/dsq_pkg.sv
hw/rtl/dsq_vram.sv
hw/rtl/dsq_range_filter.sv
hw/rtl/delayed_spike_queue_unit.sv
tb/delayed_spike_queue_unit_tb.sv
